### hw/rtl/sjenc_pkg.sv
// ----------------------------------------------------------------------------
// sjenc_pkg
// Shared types and constants for the Shift-JIS to 7-bit JIS encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sjenc_pkg;

  // depth of the command queue between front and back
  localparam int unsigned FifoDepth = 4;

  localparam logic [7:0] EscByte = 8'h1B;
  localparam logic [7:0] SoByte  = 8'h0E;
  localparam logic [7:0] SiByte  = 8'h0F;

  localparam int unsigned CfgIdxW = 3;

  // config register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ROT_EN = 3'd0,
    REG_KANA7  = 3'd1,
    REG_KESC1  = 3'd2,
    REG_KESC2  = 3'd3,
    REG_AESC1  = 3'd4,
    REG_AESC2  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic       rot_en;
    logic       kana7;
    logic [7:0] kesc1;
    logic [7:0] kesc2;
    logic [7:0] aesc1;
    logic [7:0] aesc2;
  } cfg_t;

  // one command: which mode bursts go out around the data byte(s)
  typedef struct packed {
    logic       pre_si;    // SI before the data
    logic       pre_asc;   // ASCII escape (ESC aesc1 [aesc2]) before the data
    logic       kesc;      // kanji escape (ESC kesc1 [kesc2])
    logic       so;        // SO before kana
    logic       d1_v;      // second data byte present
    logic       post_si;   // SI after the data (stream end)
    logic       post_asc;  // ASCII escape after the data (stream end)
    logic [7:0] d0;
    logic [7:0] d1;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/sjenc_front.sv
// ----------------------------------------------------------------------------
// sjenc_front
// Input side: classifies each byte, tracks lead/mode state, builds commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sjenc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sjenc_pkg::cfg_t   cfg_i,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  logic              stream_end_i,
  output logic              in_stall_o,
  input  logic              full_i,
  output logic              push_o,
  output sjenc_pkg::cmd_t   cmd_o
);
  import sjenc_pkg::*;

  logic       pend_q, pend_d;
  logic [7:0] held_q, held_d;
  logic       dbl_q, dbl_d;
  logic       kana_q, kana_d;

  logic       accept;
  logic       is_lead, is_trail, is_kana;
  logic       emits;
  logic       dbl_n, kana_n;
  logic [7:0] row1, row2, row, col, c;
  cmd_t       cmd;

  function automatic logic [7:0] rot13(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if ((v >= 8'h41 && v <= 8'h4D) || (v >= 8'h61 && v <= 8'h6D)) begin
      r = v + 8'd13;
    end else if ((v >= 8'h4E && v <= 8'h5A) || (v >= 8'h6E && v <= 8'h7A)) begin
      r = v - 8'd13;
    end
    return r;
  endfunction

  function automatic logic [7:0] rot47(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (v >= 8'h21 && v <= 8'h7E) begin
      r = v + 8'd47;
      if (r > 8'h7E) begin
        r = r - 8'd94;
      end
    end
    return r;
  endfunction

  assign c          = in_byte_i;
  assign accept     = in_valid_i & ~full_i;
  assign in_stall_o = full_i;

  assign is_lead  = (c >= 8'h81 && c <= 8'h9F) || (c >= 8'hE0 && c <= 8'hFC);
  assign is_trail = (c >= 8'h40 && c <= 8'h7E) || (c >= 8'h80 && c <= 8'hFC);
  assign is_kana  = (c >= 8'hA1 && c <= 8'hDF);

  // lead/trail to row/col, all 8-bit wraparound
  always_comb begin
    row1 = held_q - ((held_q <= 8'h9F) ? 8'h70 : 8'hB0);
    row2 = {row1[6:0], 1'b0};
    if (c < 8'h9F) begin
      col = c - ((c < 8'h7F) ? 8'h1F : 8'h20);
      row = row2 - 8'd1;
    end else begin
      col = c - 8'h7E;
      row = row2;
    end
    if (cfg_i.rot_en) begin
      row = rot47(row);
      col = rot47(col);
    end
  end

  always_comb begin
    cmd    = '0;
    emits  = 1'b1;
    dbl_n  = dbl_q;
    kana_n = kana_q;
    pend_d = pend_q;
    held_d = held_q;
    dbl_d  = dbl_q;
    kana_d = kana_q;

    if (pend_q) begin
      cmd.pre_si = ~dbl_q & kana_q;
      cmd.kesc   = ~dbl_q;
      cmd.d1_v   = 1'b1;
      dbl_n      = 1'b1;
      kana_n     = 1'b0;
      if (is_trail) begin
        cmd.d0 = row;
        cmd.d1 = col;
      end else begin
        cmd.d0 = held_q;
        cmd.d1 = c;
      end
    end else if (is_lead) begin
      if (stream_end_i) begin
        // dangling lead: close the mode, then the lead goes out raw
        cmd.pre_si  = kana_q;
        cmd.pre_asc = ~kana_q & dbl_q;
        cmd.d0      = c;
        dbl_n       = 1'b0;
        kana_n      = 1'b0;
      end else begin
        emits = 1'b0;
      end
    end else if (is_kana) begin
      cmd.pre_asc = dbl_q;
      dbl_n       = 1'b0;
      if (cfg_i.kana7) begin
        cmd.so = ~kana_q;
        kana_n = 1'b1;
        cmd.d0 = {1'b0, c[6:0]};
      end else begin
        cmd.d0 = c;
      end
    end else begin
      cmd.pre_asc = dbl_q;
      cmd.pre_si  = ~dbl_q & kana_q;
      dbl_n       = 1'b0;
      kana_n      = 1'b0;
      cmd.d0      = (~c[7] & cfg_i.rot_en) ? rot13(c) : c;
    end

    if (stream_end_i) begin
      cmd.post_si  = kana_n;
      cmd.post_asc = ~kana_n & dbl_n;
    end

    if (accept) begin
      if (stream_end_i) begin
        pend_d = 1'b0;
        dbl_d  = 1'b0;
        kana_d = 1'b0;
      end else begin
        pend_d = ~pend_q & is_lead;
        dbl_d  = dbl_n;
        kana_d = kana_n;
      end
      if (~pend_q & is_lead) begin
        held_d = c;
      end
    end
  end

  assign push_o = accept & emits;
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      dbl_q  <= 1'b0;
      kana_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      dbl_q  <= dbl_d;
      kana_q <= kana_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

`default_nettype wire

### hw/rtl/sjenc_fifo.sv
// ----------------------------------------------------------------------------
// sjenc_fifo
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sjenc_fifo #(
  parameter int unsigned Depth = sjenc_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sjenc_pkg::cmd_t   push_data_i,
  output logic              full_o,
  output logic              valid_o,
  output sjenc_pkg::cmd_t   head_o,
  input  logic              pop_i
);
  import sjenc_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push & ~do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (~do_push & do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sjenc_back.sv
// ----------------------------------------------------------------------------
// sjenc_back
// Output side: a command becomes its bytes, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sjenc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sjenc_pkg::cfg_t   cfg_i,
  input  logic              head_valid_i,
  input  sjenc_pkg::cmd_t   head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o
);
  import sjenc_pkg::*;

  // byte slots in emission order
  localparam int unsigned NSlots = 14;

  logic [NSlots-1:0] mask_q, mask_d, head_mask, cur, pick, rest;
  logic [7:0]        d0_q, d0_d, d1_q, d1_d, cur_d0, cur_d1;
  logic              oval_q, oval_d, olast_q, olast_d;
  logic [7:0]        obyte_q, obyte_d, sel;
  logic              adv, use_head;
  logic              a2_nz, k2_nz;
  logic [7:0]        slot_byte [NSlots];

  assign a2_nz = (cfg_i.aesc2 != 8'h00);
  assign k2_nz = (cfg_i.kesc2 != 8'h00);

  assign head_mask = {
    head_i.post_asc & a2_nz, head_i.post_asc, head_i.post_asc, head_i.post_si,
    head_i.d1_v, 1'b1, head_i.so,
    head_i.kesc & k2_nz, head_i.kesc, head_i.kesc,
    head_i.pre_asc & a2_nz, head_i.pre_asc, head_i.pre_asc, head_i.pre_si
  };

  assign adv      = ~oval_q | ~out_stall_i;
  assign use_head = (mask_q == '0) & head_valid_i;
  assign cur      = (mask_q != '0) ? mask_q : (head_valid_i ? head_mask : '0);
  assign cur_d0   = use_head ? head_i.d0 : d0_q;
  assign cur_d1   = use_head ? head_i.d1 : d1_q;
  assign pick     = cur & (~cur + NSlots'(1));
  assign rest     = cur & ~pick;
  assign pop_o    = use_head & adv;

  always_comb begin
    slot_byte[0]  = SiByte;
    slot_byte[1]  = EscByte;
    slot_byte[2]  = cfg_i.aesc1;
    slot_byte[3]  = cfg_i.aesc2;
    slot_byte[4]  = EscByte;
    slot_byte[5]  = cfg_i.kesc1;
    slot_byte[6]  = cfg_i.kesc2;
    slot_byte[7]  = SoByte;
    slot_byte[8]  = cur_d0;
    slot_byte[9]  = cur_d1;
    slot_byte[10] = SiByte;
    slot_byte[11] = EscByte;
    slot_byte[12] = cfg_i.aesc1;
    slot_byte[13] = cfg_i.aesc2;
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < NSlots; i++) begin
      sel = sel | (slot_byte[i] & {8{pick[i]}});
    end
  end

  always_comb begin
    mask_d  = mask_q;
    d0_d    = d0_q;
    d1_d    = d1_q;
    oval_d  = oval_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    if (adv) begin
      oval_d = (cur != '0);
      if (cur != '0) begin
        mask_d  = rest;
        obyte_d = sel;
        olast_d = (rest == '0);
        d0_d    = cur_d0;
        d1_d    = cur_d1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      oval_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d0_q    <= d0_d;
    d1_q    <= d1_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o   = oval_q;
  assign out_byte_o    = obyte_q;
  assign last_of_run_o = olast_q;

endmodule

`default_nettype wire

### hw/rtl/sjis_to_jis_escape_encoder.sv
// ----------------------------------------------------------------------------
// sjis_to_jis_escape_encoder
// Shift-JIS byte stream in, 7-bit JIS (escape / SO-SI shifted) stream out.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | sink      | in_valid_i / in_stall_o | in_byte_i, stream_end_i
//  out     | source    | out_valid_o/out_stall_i | out_byte_o, last_of_run_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One input byte is taken per cycle while the command queue has room.
//  The output side sends one word per cycle unless stalled; a byte that
//  expands into k words (escape bursts, kanji pairs, stream-end close)
//  holds the back end until all k are out. A lead byte without stream end
//  sends nothing. A command passes the queue, then the output register.
//  Reset clears the mode flags, the pending lead, the queue and the output
//  valid; config registers return to their defaults. No clearing pass.
//  Front and back stall independently through the FifoDepth-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sjis_to_jis_escape_encoder #(
  parameter int unsigned FifoDepth = sjenc_pkg::FifoDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input byte stream
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      in_byte_i,
  input  logic                            stream_end_i,
  // output byte stream
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_byte_o,
  output logic                            last_of_run_o,
  // config writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sjenc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                      cfg_data_i
);
  import sjenc_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic push, full, head_valid, pop;
  cmd_t push_cmd, head_cmd;

  // config registers are always writable
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROT_EN: cfg_d.rot_en = cfg_data_i[0];
        REG_KANA7:  cfg_d.kana7  = cfg_data_i[0];
        REG_KESC1:  cfg_d.kesc1  = cfg_data_i;
        REG_KESC2:  cfg_d.kesc2  = cfg_data_i;
        REG_AESC1:  cfg_d.aesc1  = cfg_data_i;
        REG_AESC2:  cfg_d.aesc2  = cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_en <= 1'b0;
      cfg_q.kana7  <= 1'b0;
      cfg_q.kesc1  <= 8'h24;  // ESC $ B
      cfg_q.kesc2  <= 8'h42;
      cfg_q.aesc1  <= 8'h28;  // ESC ( B
      cfg_q.aesc2  <= 8'h42;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: classify, track modes, build one command per producing byte
  sjenc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .stream_end_i (stream_end_i),
    .in_stall_o   (in_stall_o),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  sjenc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .valid_o     (head_valid),
    .head_o      (head_cmd),
    .pop_i       (pop)
  );

  // back: walk the command's byte slots into the output register
  sjenc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (head_valid),
    .head_i        (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

### hw/rtl/sjenc_chk.sv
// ----------------------------------------------------------------------------
// sjenc_chk
// Port-level checks for the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sjenc_chk (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic [7:0]                      out_byte_o,
  input  logic                            last_of_run_o
);

  // a stalled output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_of_run_o))
    else $error("output word changed while stalled");

  // the queue only fills through an accepted input byte
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted byte");

  // a full queue means the back end is busy driving words
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("queue full while output idle");

endmodule

bind sjis_to_jis_escape_encoder sjenc_chk u_chk (.*);

`default_nettype wire
